@@ src/mcde_pkg.sv @@
// ----------------------------------------------------------------------------
// mcde_pkg
// shared types and constants for the multichannel debounce edge detector
// ----------------------------------------------------------------------------
package mcde_pkg;

  localparam int CHANNELS = 9;
  localparam int RAW_W    = 9;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int IDX_W    = 4;
  localparam int OP_W     = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS  = OP_W + RAW_W + TIME_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + IDX_W + 1 + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // register map
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_ENABLED    = 2'd0;
  localparam logic [1:0] REG_ACTIVE_LOW = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd2;
  localparam logic [1:0] REG_COOLDOWN   = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_ACK   = 2'd1,
    OP_REARM = 2'd2,
    OP_SYNC  = 2'd3
  } op_t;

  // settings every cell sees
  typedef struct packed {
    logic            active_low;
    logic [MS_W-1:0] hold_ms;
    logic [MS_W-1:0] cooldown_ms;
  } cell_cfg_t;

  // item travelling down the chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              live;    // scan still looking for a detection
    logic              hit;     // some cell latched a detection
    logic [IDX_W-1:0]  hit_idx;
    logic [IDX_W-1:0]  chan;    // channel index of the receiving cell
    logic [RAW_W-1:0]  raw;     // bit 0 belongs to the receiving cell
    logic [TIME_W-1:0] now_ms;
  } token_t;

  typedef struct packed {
    logic             taken;
    logic             pending;
    logic [IDX_W-1:0] sensor;
    logic             detected;
  } result_t;

endpackage

@@ src/mcde_cell.sv @@
// ----------------------------------------------------------------------------
// mcde_cell
// one channel: debounce state, cooldown timer, and hand-off to the next cell
// ----------------------------------------------------------------------------
module mcde_cell (
  input  logic               clk,
  input  logic               rst,
  input  mcde_pkg::cell_cfg_t cfg,
  input  mcde_pkg::token_t   tok_in,
  output mcde_pkg::token_t   tok_out
);

  logic                         last_level;
  logic                         stable_level;
  logic [mcde_pkg::TIME_W-1:0]  change_time;
  logic [mcde_pkg::TIME_W-1:0]  detect_time;

  logic                         cur;
  logic                         in_cool;
  logic                         changed;
  logic                         settled;
  logic                         work;
  logic                         flip;
  logic                         hit;
  logic [mcde_pkg::TIME_W-1:0]  since_detect;
  logic [mcde_pkg::TIME_W-1:0]  since_change;

  assign cur          = tok_in.raw[0] ^ cfg.active_low;
  assign since_detect = tok_in.now_ms - detect_time;
  assign since_change = tok_in.now_ms - change_time;
  assign in_cool      = since_detect < {{(mcde_pkg::TIME_W-mcde_pkg::MS_W){1'b0}},
                                        cfg.cooldown_ms};
  assign changed      = cur != last_level;
  // a fresh change restarts the hold time at zero
  assign settled      = changed ? (cfg.hold_ms == '0)
                                : (since_change >= {{(mcde_pkg::TIME_W-mcde_pkg::MS_W){1'b0}},
                                                    cfg.hold_ms});
  assign work = tok_in.valid && (tok_in.op == mcde_pkg::OP_SCAN) && tok_in.live && !in_cool;
  assign flip = work && settled && (stable_level != cur);
  assign hit  = flip && cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      stable_level <= 1'b0;
      change_time  <= '0;
      detect_time  <= '0;
    end else if (tok_in.valid) begin
      unique case (tok_in.op)
        mcde_pkg::OP_SCAN: begin
          if (work && changed) begin
            last_level  <= cur;
            change_time <= tok_in.now_ms;
          end
          if (flip) begin
            stable_level <= cur;
          end
          if (hit) begin
            detect_time <= tok_in.now_ms;
          end
        end
        mcde_pkg::OP_REARM: begin
          detect_time <= '0;
        end
        mcde_pkg::OP_SYNC: begin
          last_level   <= cur;
          stable_level <= cur;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.op      <= tok_in.op;
    tok_out.live    <= tok_in.live && !hit;
    tok_out.hit     <= tok_in.hit || hit;
    tok_out.hit_idx <= hit ? tok_in.chan : tok_in.hit_idx;
    tok_out.chan    <= tok_in.chan + mcde_pkg::IDX_W'(1);
    tok_out.raw     <= {1'b0, tok_in.raw[mcde_pkg::RAW_W-1:1]};
    tok_out.now_ms  <= tok_in.now_ms;
  end

endmodule

@@ src/mcde_chain.sv @@
// ----------------------------------------------------------------------------
// mcde_chain
// row of channel cells, lowest channel first
// ----------------------------------------------------------------------------
module mcde_chain (
  input  logic                clk,
  input  logic                rst,
  input  mcde_pkg::cell_cfg_t cfg,
  input  mcde_pkg::token_t    tok_in,
  output mcde_pkg::token_t    tok_out
);

  mcde_pkg::token_t tok [0:mcde_pkg::CHANNELS];

  assign tok[0]  = tok_in;
  assign tok_out = tok[mcde_pkg::CHANNELS];

  for (genvar g = 0; g < mcde_pkg::CHANNELS; g++) begin : g_cell
    mcde_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

endmodule

@@ src/multichannel_debounce_edge_detector.sv @@
// ----------------------------------------------------------------------------
// multichannel_debounce_edge_detector
// debounced sensor bank with per-channel cooldown and latched detection
// ----------------------------------------------------------------------------
// items come in on the s_ stream: op, raw pin levels and the current
// millisecond time. every item gives exactly one result transfer on the
// m_ stream: detected, sensor index, pending flag and taken flag.
// the item travels down a row of channel cells, one cell per cycle: the first
// cell works at the accepting edge, then each remaining cell in turn, then
// the pending flag settles into a holding register and the result is loaded
// into the output register. one item is in the chain at a time.
// settings go through the apb port; the user must write them only while
// idle, and the block itself does not enforce this.
// the next item is accepted as soon as the previous result sits in the
// output register, even while the receiver stalls; a stalled receiver only
// holds the block once a second result is waiting behind the first.
// reset (synchronous, active high) clears all channel levels and times,
// the pending flag and the sensor index, and restores the register
// defaults: disabled, active low, 50 ms debounce, 500 ms cooldown.
module multichannel_debounce_edge_detector (
  input  logic                        clk,
  input  logic                        rst,
  // apb configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcde_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mcde_pkg::IN_W-1:0]   s_tdata,   // op, raw_levels, now_ms
  // result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mcde_pkg::OUT_W-1:0]  m_tdata    // detected, sensor, pending, taken
);

  // configuration registers
  logic                       enabled;
  logic                       active_low;
  logic [mcde_pkg::MS_W-1:0]  hold_ms;
  logic [mcde_pkg::MS_W-1:0]  cooldown_ms;
  logic                       cfg_write;

  // control state
  logic                       busy;
  logic                       pending_flag;
  logic [mcde_pkg::IDX_W-1:0] detected_index;
  logic                       done_valid;
  mcde_pkg::result_t          done_res;
  mcde_pkg::result_t          out_res;

  logic                       in_xfer;
  logic                       done_move;
  mcde_pkg::cell_cfg_t        cell_cfg;
  mcde_pkg::token_t           tok_head;
  mcde_pkg::token_t           tok_tail;
  mcde_pkg::op_t              in_op;
  mcde_pkg::result_t          res_next;
  logic                       pending_next;
  logic [mcde_pkg::IDX_W-1:0] index_next;

  // apb: always ready, write on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      active_low  <= 1'b1;
      hold_ms     <= mcde_pkg::MS_W'(50);
      cooldown_ms <= mcde_pkg::MS_W'(500);
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        mcde_pkg::REG_ENABLED:    enabled     <= pwdata[0];
        mcde_pkg::REG_ACTIVE_LOW: active_low  <= pwdata[0];
        mcde_pkg::REG_DEBOUNCE:   hold_ms     <= pwdata[mcde_pkg::MS_W-1:0];
        mcde_pkg::REG_COOLDOWN:   cooldown_ms <= pwdata[mcde_pkg::MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mcde_pkg::REG_ENABLED:    prdata[0] = enabled;
      mcde_pkg::REG_ACTIVE_LOW: prdata[0] = active_low;
      mcde_pkg::REG_DEBOUNCE:   prdata[mcde_pkg::MS_W-1:0] = hold_ms;
      mcde_pkg::REG_COOLDOWN:   prdata[mcde_pkg::MS_W-1:0] = cooldown_ms;
      default: begin
      end
    endcase
  end

  // input side: one item in flight, released once its result is in the
  // output register
  assign s_tready = !busy;
  assign in_xfer  = s_tvalid && s_tready;
  assign in_op    = mcde_pkg::op_t'(s_tdata[mcde_pkg::OP_W-1:0]);

  assign cell_cfg.active_low  = active_low;
  assign cell_cfg.hold_ms     = hold_ms;
  assign cell_cfg.cooldown_ms = cooldown_ms;

  // a scan only has effect while enabled and with nothing pending
  always_comb begin
    tok_head.valid   = in_xfer;
    tok_head.op      = in_op;
    tok_head.live    = (in_op == mcde_pkg::OP_SCAN) && enabled && !pending_flag;
    tok_head.hit     = 1'b0;
    tok_head.hit_idx = '0;
    tok_head.chan    = '0;
    tok_head.raw     = s_tdata[mcde_pkg::OP_W +: mcde_pkg::RAW_W];
    tok_head.now_ms  = s_tdata[mcde_pkg::OP_W + mcde_pkg::RAW_W +: mcde_pkg::TIME_W];
  end

  mcde_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cell_cfg),
    .tok_in  (tok_head),
    .tok_out (tok_tail)
  );

  // settle pending flag and sensor index when the item leaves the chain
  always_comb begin
    pending_next = pending_flag;
    index_next   = detected_index;
    res_next     = '0;
    unique case (tok_tail.op)
      mcde_pkg::OP_SCAN: begin
        if (tok_tail.hit) begin
          pending_next = 1'b1;
          index_next   = tok_tail.hit_idx;
        end
        res_next.detected = tok_tail.hit;
      end
      mcde_pkg::OP_ACK: begin
        res_next.taken = pending_flag;
        pending_next   = 1'b0;
      end
      mcde_pkg::OP_REARM: begin
        pending_next = 1'b0;
      end
      default: begin
      end
    endcase
    res_next.sensor  = index_next;
    res_next.pending = pending_next;
  end

  // result waits here when the output register is still full
  assign done_move = done_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pending_flag   <= 1'b0;
      detected_index <= '0;
      done_valid     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (done_move) begin
        busy <= 1'b0;
      end
      if (tok_tail.valid) begin
        pending_flag   <= pending_next;
        detected_index <= index_next;
        done_valid     <= 1'b1;
      end else if (done_move) begin
        done_valid <= 1'b0;
      end
      if (done_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_tail.valid) begin
      done_res <= res_next;
    end
    if (done_move) begin
      out_res <= done_res;
    end
  end

  assign m_tdata = {{(mcde_pkg::OUT_W - mcde_pkg::OUT_BITS){1'b0}}, out_res};

`ifndef SYNTHESIS
  // an item only leaves the chain while the block counts itself busy
  assert property (@(posedge clk) disable iff (rst) tok_tail.valid |-> busy)
    else $error("chain result without an item in flight");

  // a finished item never lands on an unmoved result
  assert property (@(posedge clk) disable iff (rst) tok_tail.valid |-> !done_valid)
    else $error("holding register overwritten");

  // a fresh detection always leaves the pending flag set
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && out_res.detected) |-> out_res.pending)
    else $error("detection reported without pending flag");

  // the next item waits until the previous result has moved on
  assert property (@(posedge clk) disable iff (rst) done_valid |-> !s_tready)
    else $error("item accepted while a result is held back");
`endif

endmodule

@@ verif/mcde_checker.sv @@
// ----------------------------------------------------------------------------
// mcde_checker
// watches the apb port and both streams, predicts each result and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcde_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mcde_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [mcde_pkg::IN_W-1:0]   s_tdata,   // op, raw_levels, now_ms
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [mcde_pkg::OUT_W-1:0]  m_tdata,   // detected, sensor, pending, taken
  output int                          errors,
  output int                          outstanding,
  output int                          results_seen,
  output int                          detections_seen
);
  import mcde_pkg::*;

  // settings as last written
  logic              cfg_enabled;
  logic              cfg_active_low;
  logic [MS_W-1:0]   cfg_debounce;
  logic [MS_W-1:0]   cfg_cooldown;

  // per-channel debounce state
  logic              seen_lvl   [CHANNELS];
  logic              steady_lvl [CHANNELS];
  logic [TIME_W-1:0] moved_at   [CHANNELS];
  logic [TIME_W-1:0] fired_at   [CHANNELS];
  logic              alarm_held;
  logic [IDX_W-1:0]  alarm_chan;

  result_t           awaited_reports [$];
  int                fail_count   = 0;
  int                result_count = 0;
  int                detect_count = 0;

  // one item through the sensor bank, returns the report it causes
  task automatic advance_channels(input op_t op, input logic [RAW_W-1:0] raw,
                                  input logic [TIME_W-1:0] now, output result_t res);
    logic              lvl;
    logic [TIME_W-1:0] since;
    res = '0;
    case (op)
      OP_SCAN: begin
        if (cfg_enabled && !alarm_held) begin
          for (int ch = 0; ch < CHANNELS; ch++) begin
            since = now - fired_at[ch];
            if (since < cfg_cooldown) continue;
            lvl = ((ch < RAW_W) ? raw[ch] : 1'b0) ^ cfg_active_low;
            if (lvl != seen_lvl[ch]) begin
              moved_at[ch] = now;
              seen_lvl[ch] = lvl;
            end
            since = now - moved_at[ch];
            if (since >= cfg_debounce && steady_lvl[ch] != lvl) begin
              steady_lvl[ch] = lvl;
              if (lvl) begin
                alarm_chan   = IDX_W'(ch);
                alarm_held   = 1'b1;
                fired_at[ch] = now;
                res.detected = 1'b1;
                break;
              end
            end
          end
        end
      end
      OP_ACK: begin
        res.taken  = alarm_held;
        alarm_held = 1'b0;
      end
      OP_REARM: begin
        for (int ch = 0; ch < CHANNELS; ch++) fired_at[ch] = '0;
        alarm_held = 1'b0;
      end
      default: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          seen_lvl[ch]   = ((ch < RAW_W) ? raw[ch] : 1'b0) ^ cfg_active_low;
          steady_lvl[ch] = seen_lvl[ch];
        end
      end
    endcase
    res.sensor  = alarm_chan;
    res.pending = alarm_held;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      cfg_enabled    = 1'b0;
      cfg_active_low = 1'b1;
      cfg_debounce   = MS_W'(50);
      cfg_cooldown   = MS_W'(500);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        seen_lvl[ch]   = 1'b0;
        steady_lvl[ch] = 1'b0;
        moved_at[ch]   = '0;
        fired_at[ch]   = '0;
      end
      alarm_held = 1'b0;
      alarm_chan = '0;
      awaited_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ENABLED:    cfg_enabled    = pwdata[0];
          REG_ACTIVE_LOW: cfg_active_low = pwdata[0];
          REG_DEBOUNCE:   cfg_debounce   = pwdata[MS_W-1:0];
          REG_COOLDOWN:   cfg_cooldown   = pwdata[MS_W-1:0];
          default: ;
        endcase
      end
      // compare before predicting, so a stray result never meets its own item
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[OUT_BITS-1:0]);
        result_count++;
        if (awaited_reports.size() == 0) begin
          fail_count++;
          $error("result transfer with nothing expected, data %h", m_tdata);
        end else begin
          want = awaited_reports.pop_front();
          if (want.detected) detect_count++;
          if (got.detected !== want.detected) begin
            fail_count++;
            $error("detected: expected %0d, actual %0d", want.detected, got.detected);
          end
          if (got.sensor !== want.sensor) begin
            fail_count++;
            $error("sensor: expected %0d, actual %0d", want.sensor, got.sensor);
          end
          if (got.pending !== want.pending) begin
            fail_count++;
            $error("pending: expected %0d, actual %0d", want.pending, got.pending);
          end
          if (got.taken !== want.taken) begin
            fail_count++;
            $error("taken: expected %0d, actual %0d", want.taken, got.taken);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_channels(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: RAW_W],
                         s_tdata[OP_W+RAW_W +: TIME_W], want);
        awaited_reports.push_back(want);
      end
    end
    errors          <= fail_count;
    outstanding     <= awaited_reports.size();
    results_seen    <= result_count;
    detections_seen <= detect_count;
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the multichannel debounce edge detector
// ----------------------------------------------------------------------------
// a directed run through the special cases is followed by phases of random
// items under different settings. the checker beside the block predicts and
// compares every result; this module only drives the ports.
`timescale 1ns / 1ps

module testbench;
  import mcde_pkg::*;

  localparam int HOLD_CYCLES = 400;           // long receiver hold-off
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int IDLE_PAD    = CHANNELS + 4;  // a little over the item latency

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;   // op, raw_levels, now_ms
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // detected, sensor, pending, taken

  int   errors;
  int   outstanding;
  int   results_seen;
  int   detections_seen;
  int   items_sent = 0;

  // shared between the sender and the result sink
  logic no_idle   = 1'b0;   // stretch with back-to-back transfers on both sides
  logic long_hold = 1'b0;   // sink holds m_tready low for one long hold-off, then clears this flag

  multichannel_debounce_edge_detector dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mcde_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .errors          (errors),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .detections_seen (detections_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous bound, well above the slowest legal run
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // one input transfer; entered after an accepting edge, returns at the next one
  task automatic send_item(input op_t op, input logic [RAW_W-1:0] raw,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = IN_W'({now, raw, op});
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // setup cycle, then access cycle; the write lands when pready is seen
  task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop offering items and wait until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic act_low,
                                input logic [MS_W-1:0] debounce,
                                input logic [MS_W-1:0] cooldown);
    wait_idle();
    write_reg(REG_ENABLED,    32'(en));
    write_reg(REG_ACTIVE_LOW, 32'(act_low));
    write_reg(REG_DEBOUNCE,   32'(debounce));
    write_reg(REG_COOLDOWN,   32'(cooldown));
  endtask

  // result sink: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        // the sender keeps offering meanwhile, so the block fills up
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] clock_ms;
    logic [RAW_W-1:0]  pins;
    logic              en;
    logic              act_low;
    logic [MS_W-1:0]   debounce;
    logic [MS_W-1:0]   cooldown;
    int                step;
    int                roll;

    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: disabled, active low, 50 ms debounce, 500 ms cooldown
    send_item(OP_SCAN,  9'h000, 32'd0);          // disabled scan does nothing
    send_item(OP_ACK,   9'h000, 32'd1);          // nothing pending to take
    send_item(OP_REARM, 9'h1FF, 32'd2);
    send_item(OP_SYNC,  9'h1FF, 32'hFFFF_FFFF);  // all pins idle-high

    apply_settings(1'b1, 1'b1, MS_W'(50), MS_W'(500));
    send_item(OP_SCAN,  9'h000, 32'd100);        // every channel still in start-up cooldown
    send_item(OP_SCAN,  9'h000, 32'd600);        // levels move, debounce starts
    send_item(OP_SCAN,  9'h000, 32'd649);        // one short of the debounce time
    send_item(OP_SCAN,  9'h000, 32'd650);        // lowest channel latches
    send_item(OP_SCAN,  9'h000, 32'd651);        // pending detection blocks the scan
    send_item(OP_ACK,   9'h000, 32'd652);
    send_item(OP_ACK,   9'h000, 32'd653);        // second acknowledge takes nothing
    send_item(OP_SCAN,  9'h000, 32'd700);        // channel 0 cooling down, next one latches
    send_item(OP_REARM, 9'h000, 32'd700);        // drops the pending detection too
    send_item(OP_ACK,   9'h000, 32'd700);
    send_item(OP_SCAN,  9'h000, 32'd701);
    send_item(OP_ACK,   9'h000, 32'd702);
    send_item(OP_SYNC,  9'h000, 32'd750);        // all channels triggered at once
    send_item(OP_SCAN,  9'h1FF, 32'd800);

    // zero debounce and cooldown, active high, times around the wrap
    apply_settings(1'b1, 1'b0, '0, '0);
    send_item(OP_SCAN,  9'h1FF, 32'hFFFF_FFF0);
    send_item(OP_ACK,   9'h1FF, 32'hFFFF_FFF8);
    send_item(OP_SCAN,  9'h100, 32'h0000_0010);
    send_item(OP_ACK,   9'h100, 32'h0000_0011);
    send_item(OP_SCAN,  9'h1FF, 32'hFFFF_FFFF);
    send_item(OP_SYNC,  9'h000, 32'd0);

    // random phases, each under its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          en = 1'b1; act_low = 1'b0; debounce = '0; cooldown = '0; step = 3;
        end
        1: begin
          // largest hold and cooldown, time moves in big steps
          en = 1'b1; act_low = 1'b1; debounce = '1; cooldown = '1; step = 20000;
        end
        2: begin
          en = 1'b0; act_low = 1'($urandom_range(0, 1));
          debounce = MS_W'(5); cooldown = MS_W'(5); step = 4;
        end
        default: begin
          en = 1'b1; act_low = 1'($urandom_range(0, 1));
          debounce = MS_W'($urandom_range(0, 30));
          cooldown = MS_W'($urandom_range(0, 300));
          step = $urandom_range(1, 10);
        end
      endcase
      apply_settings(en, act_low, debounce, cooldown);
      clock_ms = $urandom;
      pins     = RAW_W'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_idle = (k % 100) < 15;
        if (ph == 3 && k == 40) long_hold = 1'b1;
        // pins mostly drift one channel at a time and sometimes jump at random; time moves forward by up to step
        if ($urandom_range(0, 9) < 3) pins ^= RAW_W'(1) << $urandom_range(0, RAW_W - 1);
        if ($urandom_range(0, 99) < 3) pins = RAW_W'($urandom);
        clock_ms += TIME_W'($urandom_range(0, step));
        roll = $urandom_range(0, 99);
        if (roll < 78)      send_item(OP_SCAN,  pins, clock_ms);
        else if (roll < 88) send_item(OP_ACK,   pins, clock_ms);
        else if (roll < 92) send_item(OP_REARM, pins, clock_ms);
        else if (roll < 95) send_item(OP_SYNC,  pins, clock_ms);
        else                send_item(op_t'($urandom_range(0, 3)), RAW_W'($urandom), $urandom);
      end
    end
    no_idle = 1'b0;

    // drain, then keep watching for stray results
    wait_idle();
    repeat (4 * IDLE_PAD) @(posedge clk);
    @(negedge clk);

    $display("covered %0d items over %0d setting phases, %0d results checked, %0d detections",
             items_sent, PHASES + 3, results_seen, detections_seen);
    $display("all ops, polarity and timing extremes, wrapping time and a %0d-cycle sink stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mcde_pkg.sv
src/mcde_cell.sv
src/mcde_chain.sv
src/multichannel_debounce_edge_detector.sv
verif/mcde_checker.sv
verif/testbench.sv
